### hdl/pwkcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse width key code decoder package
// Register indexes, register reset values and field widths shared by the
// decoder and its checker.
// ----------------------------------------------------------------------------
package pwkcd_pkg;

	localparam int REG_INDEX_W = 1;
	localparam int REG_DATA_W  = 8;
	localparam int KEY_W       = 6;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_START_THRESHOLD = 1'b0,
		REG_BIT_THRESHOLD   = 1'b1
	} reg_index_t;

	localparam logic [REG_DATA_W-1:0] START_THRESHOLD_RESET = 8'd30;
	localparam logic [REG_DATA_W-1:0] BIT_THRESHOLD_RESET   = 8'd3;

endpackage

### hdl/pulse_width_key_code_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse width key code decoder
// Each input word is one sample of a serial line. The decoder waits for a long
// low start period, follows a fixed run of lead edges, then measures the high
// width of the data pulses and latches the resulting code for good.
// ----------------------------------------------------------------------------
// Every accepted sample yields exactly one output word, registered in the cycle
// after it is taken. A new sample is accepted in every cycle while the output
// register is empty or being drained, so the sustained rate is one sample per
// clock while the output is not stalled; a single output register lies between
// the input handshake and the output port. The word reports done and the code,
// which stays zero until the code has been latched.
module pulse_width_key_code_decoder #(
	parameter int DATA_BITS   = 6,
	parameter int LEAD_EDGES  = 18,
	parameter int COUNT_WIDTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [pwkcd_pkg::REG_INDEX_W-1:0]   wr_index,
	input  logic [pwkcd_pkg::REG_DATA_W-1:0]    wr_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [pwkcd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] line_level
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [pwkcd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // [0] done_res, [6:1] key_value
);
	import pwkcd_pkg::*;

	localparam int DONE_PHASE = LEAD_EDGES + 2 * DATA_BITS;
	localparam int PHASE_W    = $clog2(DONE_PHASE + 1);
	localparam int CMP_W      = (COUNT_WIDTH > REG_DATA_W) ? COUNT_WIDTH : REG_DATA_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [REG_DATA_W-1:0]  start_thr_q;
	logic [REG_DATA_W-1:0]  bit_thr_q;
	logic [PHASE_W-1:0]     phase_q;
	logic [PHASE_W-1:0]     phase_d;
	logic [COUNT_WIDTH-1:0] tick_q;
	logic [COUNT_WIDTH-1:0] tick_d;
	logic [DATA_BITS-1:0]   code_q;
	logic [DATA_BITS-1:0]   code_d;
	logic                   captured_q;
	logic                   captured_d;
	logic                   out_valid_q;
	logic                   out_done_q;
	logic [KEY_W-1:0]       out_key_q;

	logic                   in_accept;
	logic                   high;
	logic                   done_now;
	logic [COUNT_WIDTH-1:0] tick_inc;
	logic [PHASE_W-1:0]     rel;
	logic [PHASE_W-2:0]     bit_idx;
	logic [CMP_W-1:0]       tick_ext;
	logic [CMP_W-1:0]       start_ext;
	logic [CMP_W-1:0]       bit_ext;
	logic [KEY_W+DATA_BITS-1:0] code_ext;

	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign high          = s_axis_tdata[0];
	assign done_now      = (phase_q == PHASE_W'(DONE_PHASE)) || captured_q;
	assign tick_inc      = (tick_q == CNT_MAX) ? tick_q : tick_q + 1'b1;
	assign rel           = phase_q - PHASE_W'(LEAD_EDGES + 1);
	assign bit_idx       = rel[PHASE_W-1:1];
	assign tick_ext      = CMP_W'(tick_q);
	assign start_ext     = CMP_W'(start_thr_q);
	assign bit_ext       = CMP_W'(bit_thr_q);
	assign code_ext      = {{KEY_W{1'b0}}, code_q};

	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		code_d     = code_q;
		captured_d = captured_q;
		if (done_now) begin
			captured_d = 1'b1;
		end else if (phase_q == '0) begin
			if (!high) begin
				tick_d = tick_inc;
			end else begin
				if (tick_ext > start_ext) begin
					phase_d = PHASE_W'(1);
				end
				tick_d = '0;
			end
		end else if (phase_q <= PHASE_W'(LEAD_EDGES)) begin
			if (phase_q[0] != high) begin
				phase_d = phase_q + 1'b1;
			end
		end else if (!rel[0]) begin
			if (high) begin
				tick_d = tick_inc;
			end else begin
				for (int i = 0; i < DATA_BITS; i++) begin
					if (bit_idx == (PHASE_W-1)'(DATA_BITS - 1 - i)) begin
						code_d[i] = tick_ext > bit_ext;
					end
				end
				phase_d = phase_q + 1'b1;
				tick_d  = '0;
			end
		end else if (high) begin
			phase_d = phase_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_thr_q <= START_THRESHOLD_RESET;
			bit_thr_q   <= BIT_THRESHOLD_RESET;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_START_THRESHOLD: start_thr_q <= wr_data;
				REG_BIT_THRESHOLD:   bit_thr_q   <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			tick_q     <= '0;
			code_q     <= '0;
			captured_q <= 1'b0;
		end else if (in_accept) begin
			phase_q    <= phase_d;
			tick_q     <= tick_d;
			code_q     <= code_d;
			captured_q <= captured_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_done_q <= done_now;
			out_key_q  <= done_now ? code_ext[KEY_W-1:0] : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_key_q, out_done_q});

endmodule

### hdl/pwkcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse width key code decoder checker
// Port-level checks of the decoder's handshakes and output stream, bound to the decoder module.
// ----------------------------------------------------------------------------
module pwkcd_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [pwkcd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import pwkcd_pkg::*;

	logic             seen_done_q;
	logic [KEY_W-1:0] seen_key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_done_q <= 1'b0;
			seen_key_q  <= '0;
		end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[0] && !seen_done_q) begin
			seen_done_q <= 1'b1;
			seen_key_q  <= m_axis_tdata[KEY_W:1];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled output word changed.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("Input stalled while the output register is empty.");

	a_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("Accepted sample produced no output word.");

	a_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[KEY_W:1] == '0)
		else $error("Code reported before it was latched.");

	a_code_latched: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && seen_done_q |->
			m_axis_tdata[0] && m_axis_tdata[KEY_W:1] == seen_key_q)
		else $error("Latched code changed or done dropped.");

endmodule

bind pulse_width_key_code_decoder pwkcd_checker u_pwkcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
